[rtl/core/rwmf_pkg.sv]
// ----------------------------------------------------------------------------
// rwmf_pkg
// shared types and constants for the rgb window median filter
// ----------------------------------------------------------------------------
`default_nettype none
package rwmf_pkg;
  localparam int MAX_WINDOW_D = 10;
  localparam int MAX_WIDTH_D  = 1024;
  localparam int MAX_HEIGHT_D = 1024;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       end_of_frame;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_GATHER, ST_WAIT, ST_SORT, ST_SEND
  } state_t;

  // control from the sequencer to each sorting cell
  typedef struct packed {
    logic clear;
    logic load;
  } cell_ctl_t;
endpackage
`default_nettype wire

[rtl/core/rgb_window_median_filter_top.sv]
// ----------------------------------------------------------------------------
// rgb_window_median_filter_top
// rgb square window median filter over a raster frame held in a frame store
// ----------------------------------------------------------------------------
//  channel  | ports                          | direction
//  in       | in_valid, in_stall, in_data    | pixel or fill tick beats in
//  out      | out_valid, out_stall, out_data | filtered pixel beats out
//  cfg      | cfg_we, cfg_index, cfg_data    | register writes
//
// an input beat that releases an output makes N*N store reads, which feed three
// sorting chains one sample a cycle, and then waits for the chains to settle.
// the frame store is a single port memory, one read or write a cycle. reset is
// synchronous; the store is not cleared. a held output beat stalls only the
// next beat that releases a pixel.
`default_nettype none
module rgb_window_median_filter_top #(
  parameter int MAX_WINDOW = rwmf_pkg::MAX_WINDOW_D,
  parameter int MAX_WIDTH  = rwmf_pkg::MAX_WIDTH_D,
  parameter int MAX_HEIGHT = rwmf_pkg::MAX_HEIGHT_D
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire rwmf_pkg::in_beat_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output rwmf_pkg::out_beat_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic [rwmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rwmf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rwmf_pkg::*;

  localparam int NCELL = MAX_WINDOW * MAX_WINDOW;
  localparam int SW    = $clog2(NCELL);
  localparam int WW    = $clog2(MAX_WINDOW + 1);
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int SR    = RW + 2;   // signed row work width
  localparam int SC    = CW + 2;

  // registers
  logic [3:0]  win_r;
  logic [10:0] wid_r, hgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= 4'd3;
      wid_r <= 11'd640;
      hgt_r <= 11'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE:  win_r <= cfg_data[3:0];
        REG_IMAGE_WIDTH:  wid_r <= cfg_data;
        REG_IMAGE_HEIGHT: hgt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [WW-1:0] n;
  logic [CW-1:0] w;
  logic [RW-1:0] h;
  always_comb begin
    if (win_r < 4'd2)                      n = WW'(2);
    else if (32'(win_r) > MAX_WINDOW)      n = WW'(MAX_WINDOW);
    else                                   n = WW'(win_r);
    if (wid_r == 11'd0)                    w = CW'(1);
    else if (32'(wid_r) > MAX_WIDTH)       w = CW'(MAX_WIDTH);
    else                                   w = CW'(wid_r);
    if (hgt_r == 11'd0)                    h = RW'(1);
    else if (32'(hgt_r) > MAX_HEIGHT)      h = RW'(MAX_HEIGHT);
    else                                   h = RW'(hgt_r);
  end

  logic [WW-1:0] half, k;
  assign half = n >> 1;
  assign k    = n - WW'(1) - half;

  // frame store
  logic [23:0]   mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [23:0]   mem_wd, mem_rd;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_rd <= mem[mem_addr];
  end

  // counters and sequencer
  state_t        st_r, st_nxt;
  logic [CW-1:0] icol_r, icol_nxt, ocol_r, ocol_nxt;
  logic [RW-1:0] irow_r, irow_nxt, orow_r, orow_nxt;
  logic [WW-1:0] wx_r, wx_nxt, wy_r, wy_nxt;
  logic          rd_pend_r, rd_pend_nxt, rd_zero_r, rd_zero_nxt;
  logic [SW:0]   cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt;
  out_beat_t     od_r, od_nxt;

  cell_ctl_t     ctl;
  logic          feed_vld;
  logic [23:0]   feed_px;
  logic [SW-1:0] sel;
  logic [7:0]    lo_r, hi_r, lo_g, hi_g, lo_b, hi_b;
  logic          busy_r, busy_g, busy_b;

  logic [RW:0]   need_r;
  logic [CW:0]   need_c;
  logic          ready;
  logic signed [SR-1:0] sr;
  logic signed [SC-1:0] sc;
  logic          inside_img;
  logic          eof;
  logic [CW-1:0] icol_p1;
  logic          take_px;

  always_comb begin
    need_r = {1'b0, orow_r} + (RW+1)'(k);
    if (need_r > {1'b0, h - RW'(1)}) need_r = {1'b0, h - RW'(1)};
    need_c = {1'b0, ocol_r} + (CW+1)'(k);
    if (need_c > {1'b0, w - CW'(1)}) need_c = {1'b0, w - CW'(1)};
    ready = irow_r >= h || {1'b0, irow_r} > need_r ||
            ({1'b0, irow_r} == need_r && {1'b0, icol_r} > need_c);
    sr = SR'(orow_r) + SR'(wy_r) - SR'(half);
    sc = SC'(ocol_r) + SC'(wx_r) - SC'(half);
    inside_img = sr >= 0 && sc >= 0 && sr < SR'(h) && sc < SC'(w);
    eof = (orow_r + RW'(1) >= h) && (ocol_r + CW'(1) >= w);
    icol_p1 = icol_r + CW'(1);
    take_px = !in_data.mode && irow_r < h;
  end

  assign sel = SW'((32'(n) * 32'(n)) / 2 - 1);

  always_comb begin
    st_nxt      = st_r;
    icol_nxt    = icol_r;
    irow_nxt    = irow_r;
    ocol_nxt    = ocol_r;
    orow_nxt    = orow_r;
    wx_nxt      = wx_r;
    wy_nxt      = wy_r;
    rd_pend_nxt = 1'b0;
    rd_zero_nxt = rd_zero_r;
    cnt_nxt     = cnt_r;
    ov_nxt      = ov_r;
    od_nxt      = od_r;
    in_stall    = 1'b1;
    mem_we      = 1'b0;
    mem_addr    = {YW'(irow_r), XW'(icol_r)};
    mem_wd      = {in_data.pixel_red, in_data.pixel_green, in_data.pixel_blue};
    ctl         = '{clear: 1'b0, load: 1'b1};
    feed_vld    = rd_pend_r;
    feed_px     = rd_zero_r ? 24'd0 : mem_rd;

    if (ov_r && !out_stall) ov_nxt = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (take_px) begin
            mem_we = 1'b1;
            if (icol_p1 >= w) begin
              icol_nxt = '0;
              irow_nxt = irow_r + RW'(1);
            end else begin
              icol_nxt = icol_p1;
            end
          end
          st_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (ready) begin
          ctl.clear = 1'b1;
          wx_nxt = '0;
          wy_nxt = '0;
          st_nxt = ST_GATHER;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_GATHER: begin
        mem_addr    = {YW'(sr), XW'(sc)};
        rd_pend_nxt = 1'b1;
        rd_zero_nxt = !inside_img;
        if (wx_r == n - WW'(1)) begin
          wx_nxt = '0;
          wy_nxt = wy_r + WW'(1);
          if (wy_r == n - WW'(1)) st_nxt = ST_WAIT;
        end else begin
          wx_nxt = wx_r + WW'(1);
        end
      end
      ST_WAIT: begin
        cnt_nxt = (SW+1)'(2);
        st_nxt  = ST_SORT;
      end
      ST_SORT: begin
        // wait for the last displaced value to come to rest
        if (cnt_r != '0) cnt_nxt = cnt_r - (SW+1)'(1);
        else if (!busy_r && !busy_g && !busy_b) st_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt.out_red   = 8'((9'(lo_r) + 9'(hi_r)) >> 1);
          od_nxt.out_green = 8'((9'(lo_g) + 9'(hi_g)) >> 1);
          od_nxt.out_blue  = 8'((9'(lo_b) + 9'(hi_b)) >> 1);
          od_nxt.end_of_frame = eof;
          if (eof) begin
            icol_nxt = '0;
            irow_nxt = '0;
            ocol_nxt = '0;
            orow_nxt = '0;
          end else if (ocol_r + CW'(1) >= w) begin
            ocol_nxt = '0;
            orow_nxt = orow_r + RW'(1);
          end else begin
            ocol_nxt = ocol_r + CW'(1);
          end
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      icol_r    <= '0;
      irow_r    <= '0;
      ocol_r    <= '0;
      orow_r    <= '0;
      ov_r      <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      icol_r    <= icol_nxt;
      irow_r    <= irow_nxt;
      ocol_r    <= ocol_nxt;
      orow_r    <= orow_nxt;
      ov_r      <= ov_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wx_r      <= wx_nxt;
    wy_r      <= wy_nxt;
    rd_zero_r <= rd_zero_nxt;
    cnt_r     <= cnt_nxt;
    od_r      <= od_nxt;
  end

  rwmf_sort_chain #(.NCELL(NCELL)) u_red (
    .clk(clk), .ctl(ctl), .feed_vld(feed_vld), .feed_val(feed_px[23:16]),
    .sel(sel), .lo_val(lo_r), .hi_val(hi_r), .busy(busy_r));
  rwmf_sort_chain #(.NCELL(NCELL)) u_green (
    .clk(clk), .ctl(ctl), .feed_vld(feed_vld), .feed_val(feed_px[15:8]),
    .sel(sel), .lo_val(lo_g), .hi_val(hi_g), .busy(busy_g));
  rwmf_sort_chain #(.NCELL(NCELL)) u_blue (
    .clk(clk), .ctl(ctl), .feed_vld(feed_vld), .feed_val(feed_px[7:0]),
    .sel(sel), .lo_val(lo_b), .hi_val(hi_b), .busy(busy_b));

  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule
`default_nettype wire

[rtl/core/rwmf_sort_cell.sv]
// ----------------------------------------------------------------------------
// rwmf_sort_cell
// one cell of an insertion sorting chain: keeps the smaller value, passes the
// larger value to its right neighbor
// ----------------------------------------------------------------------------
`default_nettype none
module rwmf_sort_cell (
  input  wire logic                  clk,
  input  wire rwmf_pkg::cell_ctl_t   ctl,
  input  wire logic                  in_vld,
  input  wire logic [7:0]            in_val,
  output logic                       out_vld,
  output logic [7:0]                 out_val,
  output logic                       held_vld,
  output logic [7:0]                 held_val
);
  import rwmf_pkg::*;

  logic       hv_r, ov_r;
  logic [7:0] hd_r, od_r;
  logic       hv_nxt, ov_nxt;
  logic [7:0] hd_nxt, od_nxt;

  always_comb begin
    hv_nxt = hv_r;
    hd_nxt = hd_r;
    ov_nxt = 1'b0;
    od_nxt = od_r;
    if (ctl.clear) begin
      hv_nxt = 1'b0;
    end else if (ctl.load && in_vld) begin
      if (!hv_r) begin
        hv_nxt = 1'b1;
        hd_nxt = in_val;
      end else if (in_val < hd_r) begin
        hd_nxt = in_val;
        ov_nxt = 1'b1;
        od_nxt = hd_r;
      end else begin
        ov_nxt = 1'b1;
        od_nxt = in_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    hv_r <= hv_nxt;
    ov_r <= ov_nxt;
    hd_r <= hd_nxt;
    od_r <= od_nxt;
  end

  assign out_vld  = ov_r;
  assign out_val  = od_r;
  assign held_vld = hv_r;
  assign held_val = hd_r;
endmodule
`default_nettype wire

[rtl/core/rwmf_sort_chain.sv]
// ----------------------------------------------------------------------------
// rwmf_sort_chain
// row of sorting cells for one colour channel; after a feed the cells hold
// the samples in ascending order
// ----------------------------------------------------------------------------
`default_nettype none
module rwmf_sort_chain #(
  parameter int NCELL = 100
) (
  input  wire logic                 clk,
  input  wire rwmf_pkg::cell_ctl_t  ctl,
  input  wire logic                 feed_vld,
  input  wire logic [7:0]           feed_val,
  input  wire logic [$clog2(NCELL)-1:0] sel,
  output logic [7:0]                lo_val,
  output logic [7:0]                hi_val,
  output logic                      busy
);
  import rwmf_pkg::*;

  logic [NCELL:0]     v;
  logic [7:0]         d [NCELL+1];
  logic [NCELL-1:0]   hv;
  logic [7:0]         hd [NCELL];

  assign v[0] = feed_vld;
  assign d[0] = feed_val;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rwmf_sort_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .in_vld   (v[i]),
      .in_val   (d[i]),
      .out_vld  (v[i+1]),
      .out_val  (d[i+1]),
      .held_vld (hv[i]),
      .held_val (hd[i])
    );
  end

  // any beat still travelling down the row
  assign busy    = |v[NCELL-1:1];
  assign lo_val  = hd[sel];
  assign hi_val  = hd[sel + 1'b1];
endmodule
`default_nettype wire
